FILE: src/bpfa_pkg.sv
// bitmap page frame allocator: shared types and constants
// no dependencies
package bpfa_pkg;

    localparam logic [2:0] MODE_ALLOC   = 3'd0;
    localparam logic [2:0] MODE_FREE    = 3'd1;
    localparam logic [2:0] MODE_ADDFREE = 3'd2;
    localparam logic [2:0] MODE_RESERVE = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;
    localparam logic [2:0] MODE_REINIT  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_DBLFREE = 2'd3;

    localparam logic CFG_FIRST_FRAME = 1'b0;
    localparam logic CFG_PAGE_COUNT  = 1'b1;

    localparam logic [31:0] BAD_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] address;
        logic [48:0] length;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] page_address;
        logic        page_is_free;
        logic [12:0] free_count;
        logic [31:0] bad_free_count;
    } rsp_t;

endpackage

FILE: src/bitmap_page_frame_allocator.sv
// bitmap page frame allocator, next-fit, one used bit per page frame
// depends on bpfa_pkg
//
//  channel | signals                                   | beat accepted when
//  cmd     | start, busy, cmd                          | start && !busy
//  rsp     | done, rsp                                 | done (one cycle, no stall)
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// the used map is one synchronous single-port ram of 1-bit entries, one read
// or write per cycle, so each entry visited takes a read and a write-back state;
// free and query: prep, bounds check, read, write, result; outside skips to result;
// alloc: prep, a read and write-back per entry scanned (at most live pages), result;
// add free and reserve: prep, a read and write-back per page in the clipped range, result;
// reinit: a clearing pass over the map; unknown modes and ignored ranges: prep, then result;
// busy is high during the clearing pass over all MAX_PAGES entries after reset;
// a new beat may be accepted in the result cycle; results cannot be stalled
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bpfa_pkg::cmd_t      cmd,
    output logic                done,
    output bpfa_pkg::rsp_t      rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int PS = $clog2(PAGE_BYTES);
    localparam int FW = 50 - PS;      // frame number width incl. range end carry

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_RD, S_CHK, S_WR, S_RESP
    } state_t;

    logic            mem [MAX_PAGES];
    logic            rdata_reg;
    logic            we, re;
    logic [AW-1:0]   maddr;
    logic            wbit;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[maddr] <= wbit;
        if (re)
            rdata_reg <= mem[maddr];
    end

    state_t          state_reg;
    logic [35:0]     first_reg;
    logic [12:0]     pcount_reg;
    logic [12:0]     free_reg;
    logic [AW:0]     hint_reg;
    logic [31:0]     bad_reg;
    logic [2:0]      mode_reg;
    logic [AW:0]     cur_reg;      // current entry
    logic [AW:0]     end_reg;      // exclusive end
    logic            wrap_reg;     // alloc second pass
    logic            outside_reg;
    logic [47:0]     addr_reg;
    logic [48:0]     len_reg;
    bpfa_pkg::rsp_t  rsp_reg;
    logic            done_reg;

    // live page count, clamped to the store
    logic [AW:0] live;
    assign live = ({7'd0, pcount_reg} > 20'(MAX_PAGES)) ? (AW+1)'(MAX_PAGES)
                                                       : (AW+1)'(pcount_reg);

    // range arithmetic on frame numbers
    logic [49:0]    endb;
    logic [FW-1:0]  afr, efr, lo_f, hi_f, top_f, ff_ext;
    logic           arem, erem;
    assign endb   = {2'b00, addr_reg} + {1'b0, len_reg};
    assign afr    = FW'(addr_reg >> PS);
    assign arem   = |addr_reg[PS-1:0];
    assign efr    = FW'(endb >> PS);
    assign erem   = |endb[PS-1:0];
    assign ff_ext = FW'(first_reg);
    assign top_f  = ff_ext + FW'(live);

    always_comb
    begin
        if (mode_reg == bpfa_pkg::MODE_ADDFREE)
        begin
            lo_f = afr + FW'(arem);
            if (lo_f == '0)
                lo_f = FW'(1);
            hi_f = efr;
        end
        else
        begin
            lo_f = afr;
            hi_f = efr + FW'(erem);
        end
        if (lo_f < ff_ext)
            lo_f = ff_ext;
        if (hi_f > top_f)
            hi_f = top_f;
    end

    logic [47:0] paddr;
    assign paddr = 48'(({12'd0, first_reg} + 48'(cur_reg[AW-1:0])) << PS);

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        wbit  = 1'b1;
        maddr = cur_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR: we = 1'b1;
            S_RD:    re = 1'b1;
            S_WR:
            begin
                // a query leaves its entry untouched
                we   = (mode_reg != bpfa_pkg::MODE_QUERY);
                wbit = (mode_reg != bpfa_pkg::MODE_ADDFREE) &&
                       (mode_reg != bpfa_pkg::MODE_FREE);
            end
            default: ;
        endcase
    end

    logic [47:0] fr_q;
    assign fr_q = addr_reg >> PS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            first_reg  <= '0;
            pcount_reg <= 13'd4096;
            free_reg   <= '0;
            hint_reg   <= '0;
            bad_reg    <= '0;
            cur_reg    <= '0;
            done_reg   <= 1'b0;
            mode_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bpfa_pkg::CFG_FIRST_FRAME)
                    first_reg <= cfg_data[35:0];
                else
                    pcount_reg <= cfg_data[12:0];
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    cur_reg <= cur_reg + 1'b1;
                    if (cur_reg == (AW+1)'(MAX_PAGES - 1))
                    begin
                        cur_reg <= '0;
                        state_reg <= (mode_reg == bpfa_pkg::MODE_REINIT) ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE:
                if (start)
                begin
                    mode_reg <= cmd.mode;
                    addr_reg <= cmd.address;
                    len_reg  <= cmd.length;
                    rsp_reg  <= '0;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    state_reg <= S_RESP;
                    unique case (mode_reg)
                        bpfa_pkg::MODE_ALLOC:
                        begin
                            wrap_reg <= 1'b0;
                            if (free_reg == '0)
                                rsp_reg.status <= bpfa_pkg::ST_NOMEM;
                            else if (hint_reg < live)
                            begin
                                cur_reg <= hint_reg;
                                end_reg <= live;
                                state_reg <= S_RD;
                            end
                            else if (live != '0)
                            begin
                                wrap_reg <= 1'b1;
                                cur_reg <= '0;
                                end_reg <= live;
                                state_reg <= S_RD;
                            end
                            else
                                rsp_reg.status <= bpfa_pkg::ST_NOMEM;
                        end
                        bpfa_pkg::MODE_FREE, bpfa_pkg::MODE_QUERY:
                        begin
                            outside_reg <= (fr_q < {12'd0, first_reg}) ||
                                (fr_q - {12'd0, first_reg} >= 48'(live));
                            cur_reg <= (AW+1)'(fr_q - {12'd0, first_reg});
                            state_reg <= S_CHK;
                        end
                        bpfa_pkg::MODE_ADDFREE, bpfa_pkg::MODE_RESERVE:
                        begin
                            cur_reg <= (AW+1)'(lo_f - ff_ext);
                            end_reg <= (AW+1)'(hi_f - ff_ext);
                            if (lo_f < hi_f &&
                                ((mode_reg == bpfa_pkg::MODE_ADDFREE &&
                                  len_reg >= 49'(PAGE_BYTES)) ||
                                 (mode_reg == bpfa_pkg::MODE_RESERVE && len_reg != '0)))
                                state_reg <= S_RD;
                        end
                        bpfa_pkg::MODE_REINIT:
                        begin
                            free_reg <= '0;
                            hint_reg <= '0;
                            bad_reg  <= '0;
                            cur_reg  <= '0;
                            state_reg <= S_CLEAR;
                        end
                        default: ;
                    endcase
                end
                S_CHK:
                begin
                    // free and query bounds check before the read
                    if (outside_reg)
                    begin
                        if (mode_reg == bpfa_pkg::MODE_FREE)
                        begin
                            rsp_reg.status <= bpfa_pkg::ST_OUTSIDE;
                            if (bad_reg != bpfa_pkg::BAD_SAT)
                                bad_reg <= bad_reg + 1'b1;
                        end
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        end_reg <= cur_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_WR;
                S_WR:
                begin
                    // rdata_reg holds the used bit of cur_reg; write-back goes out this cycle
                    state_reg <= S_RD;
                    unique case (mode_reg)
                        bpfa_pkg::MODE_ALLOC:
                        if (!rdata_reg)
                        begin
                            free_reg <= free_reg - 1'b1;
                            hint_reg <= cur_reg + 1'b1;
                            rsp_reg.page_address <= paddr;
                            state_reg <= S_RESP;
                        end
                        else if (cur_reg + 1'b1 < end_reg)
                            cur_reg <= cur_reg + 1'b1;
                        else if (!wrap_reg && hint_reg != '0)
                        begin
                            wrap_reg <= 1'b1;
                            cur_reg <= '0;
                            end_reg <= (hint_reg < live) ? hint_reg : live;
                        end
                        else
                        begin
                            rsp_reg.status <= bpfa_pkg::ST_NOMEM;
                            state_reg <= S_RESP;
                        end
                        bpfa_pkg::MODE_FREE:
                        begin
                            state_reg <= S_RESP;
                            if (!rdata_reg)
                            begin
                                rsp_reg.status <= bpfa_pkg::ST_DBLFREE;
                                if (bad_reg != bpfa_pkg::BAD_SAT)
                                    bad_reg <= bad_reg + 1'b1;
                            end
                            else
                            begin
                                free_reg <= free_reg + 1'b1;
                                if (cur_reg < hint_reg)
                                    hint_reg <= cur_reg;
                            end
                        end
                        bpfa_pkg::MODE_QUERY:
                        begin
                            rsp_reg.page_is_free <= !rdata_reg;
                            state_reg <= S_RESP;
                        end
                        default:
                        begin
                            if (mode_reg == bpfa_pkg::MODE_ADDFREE && rdata_reg)
                                free_reg <= free_reg + 1'b1;
                            if (mode_reg == bpfa_pkg::MODE_RESERVE && !rdata_reg)
                                free_reg <= free_reg - 1'b1;
                            cur_reg <= cur_reg + 1'b1;
                            if (cur_reg + 1'b1 >= end_reg)
                                state_reg <= S_RESP;
                        end
                    endcase
                end
                S_RESP:
                begin
                    done_reg <= 1'b1;
                    rsp_reg.free_count     <= free_reg;
                    rsp_reg.bad_free_count <= bad_reg;
                    mode_reg <= bpfa_pkg::MODE_ALLOC;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/bpfa_checker.sv
// port-level checks for the bitmap page frame allocator
// depends on bpfa_pkg and bitmap_page_frame_allocator
module bpfa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input bpfa_pkg::rsp_t rsp,
    input logic           cfg_ready
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("no busy after accept");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_alloc_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != bpfa_pkg::ST_OK |-> rsp.page_address == '0)
        else $error("address with error status");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !busy) else $error("cfg ready while busy");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .rsp(rsp), .cfg_ready(cfg_ready)
);

FILE: tb/testbench.sv
// testbench for the bitmap page frame allocator: scoreboard class, drivers and stimulus
// depends on bpfa_pkg and bitmap_page_frame_allocator
`timescale 1ns / 1ps

// predictor of the allocator and store of pending responses
class alloc_scoreboard;
    localparam int unsigned PAGES = 4096;
    localparam longint unsigned PB = 4096;

    bit               used_map [PAGES];
    int unsigned      free_cnt;
    int unsigned      hint;
    logic [31:0]      bad_cnt;
    longint unsigned  base_frame;
    longint unsigned  page_count;
    bpfa_pkg::rsp_t   pending [$];
    int               errors;
    int               checked;
    int               accepted;

    function new();
        wipe();
        base_frame  = 0;
        page_count  = PAGES;
        errors      = 0;
        checked     = 0;
        accepted    = 0;
    endfunction

    function void wipe();
        foreach (used_map[i]) used_map[i] = 1'b1;
        free_cnt = 0;
        hint     = 0;
        bad_cnt  = '0;
    endfunction

    function longint unsigned live();
        return (page_count > PAGES) ? PAGES : page_count;
    endfunction

    // map slot of a frame, or the live count when outside
    function longint unsigned slot_of(longint unsigned frame);
        if (frame < base_frame)
            return live();
        return (frame - base_frame < live()) ? frame - base_frame : live();
    endfunction

    function void set_reg(logic idx, logic [63:0] data);
        if (idx == bpfa_pkg::CFG_FIRST_FRAME)
            base_frame = data[35:0];
        else
            page_count = data[12:0];
    endfunction

    function void count_bad();
        if (bad_cnt != bpfa_pkg::BAD_SAT)
            bad_cnt = bad_cnt + 1;
    endfunction

    // clip [lo, hi) to the map and mark each page
    function void walk(longint unsigned lo, longint unsigned hi, bit to_free);
        longint unsigned top;
        longint unsigned e;
        top = base_frame + live();
        if (lo < base_frame) lo = base_frame;
        if (hi > top) hi = top;
        for (longint unsigned f = lo; f < hi; f++)
        begin
            e = f - base_frame;
            if (to_free && used_map[e])
            begin
                used_map[e] = 1'b0;
                free_cnt++;
            end
            else if (!to_free && !used_map[e])
            begin
                used_map[e] = 1'b1;
                free_cnt--;
            end
        end
    endfunction

    function void note_cmd(bpfa_pkg::cmd_t c);
        bpfa_pkg::rsp_t   r;
        longint unsigned  n;
        longint unsigned  e;
        longint unsigned  addr;
        longint unsigned  len;
        longint unsigned  lo;
        longint unsigned  hi;
        longint unsigned  endb;
        bit               found;
        r     = '0;
        n     = live();
        addr  = c.address;
        len   = c.length;
        found = 1'b0;
        e     = 0;
        accepted++;
        case (c.mode)
            bpfa_pkg::MODE_ALLOC:
            begin
                if (free_cnt != 0)
                begin
                    for (e = hint; e < n; e++)
                        if (!used_map[e]) begin found = 1'b1; break; end
                    if (!found)
                        for (e = 0; e < hint && e < n; e++)
                            if (!used_map[e]) begin found = 1'b1; break; end
                end
                if (found)
                begin
                    used_map[e] = 1'b1;
                    free_cnt--;
                    hint = e + 1;
                    r.page_address = (base_frame + e) * PB;
                end
                else
                    r.status = bpfa_pkg::ST_NOMEM;
            end
            bpfa_pkg::MODE_FREE:
            begin
                e = slot_of(addr / PB);
                if (e >= n)
                begin
                    r.status = bpfa_pkg::ST_OUTSIDE;
                    count_bad();
                end
                else if (!used_map[e])
                begin
                    r.status = bpfa_pkg::ST_DBLFREE;
                    count_bad();
                end
                else
                begin
                    used_map[e] = 1'b0;
                    free_cnt++;
                    if (e < hint) hint = e;
                end
            end
            bpfa_pkg::MODE_ADDFREE:
                if (len >= PB)
                begin
                    lo = addr / PB + ((addr % PB != 0) ? 1 : 0);
                    hi = (addr + len) / PB;
                    if (lo == 0) lo = 1;
                    walk(lo, hi, 1'b1);
                end
            bpfa_pkg::MODE_RESERVE:
                if (len != 0)
                begin
                    endb = addr + len;
                    hi   = endb / PB + ((endb % PB != 0) ? 1 : 0);
                    walk(addr / PB, hi, 1'b0);
                end
            bpfa_pkg::MODE_QUERY:
            begin
                e = slot_of(addr / PB);
                if (e < n && !used_map[e]) r.page_is_free = 1'b1;
            end
            bpfa_pkg::MODE_REINIT:
                wipe();
            default: ;
        endcase
        r.free_count     = free_cnt[12:0];
        r.bad_free_count = bad_cnt;
        pending.push_back(r);
    endfunction

    function void check_rsp(bpfa_pkg::rsp_t act);
        bpfa_pkg::rsp_t x;
        if (pending.size() == 0)
        begin
            $error("response beat with nothing pending");
            errors++;
            return;
        end
        x = pending.pop_front();
        checked++;
        if (act.status !== x.status)
        begin
            $error("status: expected %0d, got %0d", x.status, act.status);
            errors++;
        end
        if (act.page_address !== x.page_address)
        begin
            $error("page_address: expected %h, got %h", x.page_address, act.page_address);
            errors++;
        end
        if (act.page_is_free !== x.page_is_free)
        begin
            $error("page_is_free: expected %0d, got %0d", x.page_is_free, act.page_is_free);
            errors++;
        end
        if (act.free_count !== x.free_count)
        begin
            $error("free_count: expected %0d, got %0d", x.free_count, act.free_count);
            errors++;
        end
        if (act.bad_free_count !== x.bad_free_count)
        begin
            $error("bad_free_count: expected %0d, got %0d", x.bad_free_count,
                   act.bad_free_count);
            errors++;
        end
    endfunction
endclass

module testbench;
    // undefined modes, the block must leave everything alone
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam longint unsigned PB      = 4096;
    localparam longint unsigned FF_MAX  = 64'hF_FFFF_FFFF;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bpfa_pkg::cmd_t cmd;
    logic           done;
    bpfa_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic           cfg_index;
    logic [63:0]    cfg_data;

    alloc_scoreboard sb;

    bitmap_page_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // every response beat is checked at the edge that ends its cycle
    always @(posedge clk)
        if (rst_n && done)
            sb.check_rsp(rsp);

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #1000ms;
        $display("Verification failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // one command beat; start stays high across back-to-back beats
    task automatic send_cmd(bpfa_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        sb.note_cmd(c);
    endtask

    // sender holds off until every pending response has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // register beat, only while the block is idle; junk in the unused upper bits
    task automatic write_reg(logic idx, longint unsigned value);
        logic [63:0] d;
        drain();
        d = {$urandom, $urandom};
        if (idx == bpfa_pkg::CFG_FIRST_FRAME)
            d[35:0] = value[35:0];
        else
            d[12:0] = value[12:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    function automatic bpfa_pkg::cmd_t make_cmd(logic [2:0] m, longint unsigned a,
                                                longint unsigned l);
        bpfa_pkg::cmd_t c;
        c.mode    = m;
        c.address = a[47:0];
        c.length  = l[48:0];
        return c;
    endfunction

    // byte address of a page near the map, sometimes just outside, sometimes unaligned
    function automatic longint unsigned near_addr();
        longint signed   slot;
        longint unsigned a;
        slot = longint'($urandom_range(sb.live() + 4)) - 2;
        a = (sb.base_frame + slot) * PB;
        if ($urandom_range(3) == 0)
            a += $urandom_range(PB - 1);
        return a & 64'hFFFF_FFFF_FFFF;
    endfunction

    // mostly well-formed traffic around the map, some raw noise
    function automatic bpfa_pkg::cmd_t rand_cmd();
        int r;
        longint unsigned pages;
        r = $urandom_range(99);
        pages = $urandom_range(18);
        if (r < 30) return make_cmd(bpfa_pkg::MODE_ALLOC, {$urandom, $urandom},
                                    {$urandom, $urandom});
        if (r < 55) return make_cmd(bpfa_pkg::MODE_FREE, near_addr(), 0);
        if (r < 67) return make_cmd(bpfa_pkg::MODE_ADDFREE, near_addr(),
                                    pages * PB + $urandom_range(PB) - PB / 2);
        if (r < 77) return make_cmd(bpfa_pkg::MODE_RESERVE, near_addr(),
                                    pages * PB / 2 + $urandom_range(PB));
        if (r < 91) return make_cmd(bpfa_pkg::MODE_QUERY, near_addr(), 0);
        if (r < 92) return make_cmd(bpfa_pkg::MODE_REINIT, near_addr(), 0);
        if (r < 94) return make_cmd(($urandom_range(1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7,
                                    {$urandom, $urandom}, {$urandom, $urandom});
        return make_cmd(3'($urandom_range(5)), {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    task automatic run_phase(longint unsigned ff, longint unsigned pc, int items);
        write_reg(bpfa_pkg::CFG_FIRST_FRAME, ff);
        write_reg(bpfa_pkg::CFG_PAGE_COUNT, pc);
        // open up the map, frame 0 apart, so allocs have something to find
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, (ff * PB) & 64'hFFFF_FFFF_FFFF,
                          (sb.live() + 1) * PB));
        for (int i = 0; i < items; i++)
        begin
            send_cmd(rand_cmd());
            if ($urandom_range(199) == 0)
                drain();
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = bpfa_pkg::CFG_FIRST_FRAME;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset map, every mode and the edge cases
        send_cmd(make_cmd(bpfa_pkg::MODE_ALLOC, 0, 0));                   // empty map
        send_cmd(make_cmd(bpfa_pkg::MODE_QUERY, 5 * PB, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_FREE, 5 * PB + 17, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_FREE, 5 * PB, 0));               // double free
        send_cmd(make_cmd(bpfa_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF, 0));   // outside
        send_cmd(make_cmd(bpfa_pkg::MODE_QUERY, 5 * PB, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_QUERY, 64'hFFFF_FFFF_FFFF, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 0, PB - 1));            // shorter than a page
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 0, 12 * PB));           // frame 0 stays used
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 20 * PB + 1, 3 * PB));  // unaligned base
        send_cmd(make_cmd(bpfa_pkg::MODE_QUERY, 7 * PB, 0));              // free page stays free
        send_cmd(make_cmd(bpfa_pkg::MODE_QUERY, 7 * PB, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_ALLOC, 0, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_ALLOC, 0, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_FREE, PB, 0));                   // hint drops
        send_cmd(make_cmd(bpfa_pkg::MODE_ALLOC, 0, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_RESERVE, 3 * PB, 0));            // zero length
        send_cmd(make_cmd(bpfa_pkg::MODE_RESERVE, 4 * PB + 5, 1));
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 4090 * PB, 64'h1_0000_0000_0000));
        send_cmd(make_cmd(bpfa_pkg::MODE_RESERVE, 4094 * PB, 64'h1_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(bpfa_pkg::MODE_ADDFREE, 64'hFFFF_FFFF_F000, 64'h1_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(bpfa_pkg::MODE_RESERVE, 64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(MODE_SPARE_6, 64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF));
        send_cmd(make_cmd(MODE_SPARE_7, 0, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_REINIT, 0, 0));
        send_cmd(make_cmd(bpfa_pkg::MODE_ALLOC, 0, 0));
        drain();

        // random phases over several map settings, large maps kept short
        run_phase(0, 16, 300);
        run_phase(FF_MAX, 8, 250);
        run_phase($urandom_range(1000), 64, 300);
        run_phase(0, 0, 80);
        run_phase({$urandom_range(15), $urandom}, 1, 150);
        run_phase(64'h1_0000, 8191, 60);
        run_phase(0, 4096, 60);
        run_phase({$urandom_range(15), $urandom}, 200, 300);
        // shrink the map under free pages: free count still sees the whole store
        write_reg(bpfa_pkg::CFG_PAGE_COUNT, 5);
        for (int i = 0; i < 120; i++)
            send_cmd(rand_cmd());
        run_phase(FF_MAX - 3, 33, 300);

        drain();
        repeat (50) @(posedge clk);
        $display("ran %0d commands over ten map settings, %0d responses checked",
                 sb.accepted, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
